FILE: rtl/itf_pkg.sv
// Shared types, codes and character helpers for the integer-to-text formatter.
package itf_pkg;

  localparam int VALUE_W          = 64;
  localparam int FW_W             = 6;
  localparam int BCD_DIGITS       = 20;
  localparam int BCD_W            = 4 * BCD_DIGITS;
  localparam int DABBLE_STEPS     = VALUE_W;
  localparam int STACK_DEPTH      = 32;
  localparam int DEF_MAX_FIELD_W  = 48;
  localparam int IN_TDATA_W       = 80;

  // Radix select codes
  localparam logic [1:0] MODE_OCT = 2'd0;
  localparam logic [1:0] MODE_DEC = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;

  // Decimal sign codes
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_PLUS  = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;
  localparam logic [1:0] SIGN_MINUS = 2'd3;

  // ASCII characters
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DABBLE,
    S_SPLIT,
    S_PADCALC,
    S_PREFIX_ZERO,
    S_PREFIX_X,
    S_SIGN,
    S_LPAD,
    S_DIGIT,
    S_RPAD
  } itf_state_t;

  // Control from the sequencer to the digit stack
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } itf_stack_ctrl_t;

  // One digit in 0..15 to its ASCII symbol
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic uc);
    logic [7:0] base;
    base = uc ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return base + {4'b0, d - 4'd10};
  endfunction

endpackage

FILE: rtl/integer_to_text_formatter.sv
// Top level of the integer-to-text formatter: input capture, digit split and text sequencer.
//
// Takes one 64-bit magnitude per input beat and sends its printf-style text one ASCII
// character per output beat, most significant first, tlast on the final character.
// Work per item: an accept step; for decimal only, a bit-serial binary-to-BCD conversion
// and a handoff; then one digit or comma per cycle (at most 29 of them) into the digit
// stack; a step to work out the padding; then one character per cycle (at most
// MAX_FIELD_WIDTH + 2 of them) while the output side takes beats. The next item is taken
// in the cycle after the final character enters the output register, so it converts while
// that character still waits for the sink. Field width counts digits, commas and padding
// only and saturates at MAX_FIELD_WIDTH; prefix ("0" or "0x", only for a nonzero value)
// and sign (decimal only) come on top. Radix select three acts as hex.
module integer_to_text_formatter #(
  parameter int MAX_FIELD_WIDTH = itf_pkg::DEF_MAX_FIELD_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // value[63:0], mode[65:64], field_width[71:66], sign_mode[73:72], group_digits[74],
  // left_justify[75], zero_pad[76], alt_form[77], upper_case[78], zero fill[79]
  input  logic [itf_pkg::IN_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // character[7:0]
  output logic [7:0]                     m_tdata,
  output logic                           m_tlast
);
  import itf_pkg::*;

  localparam logic [FW_W-1:0] MAX_FW = FW_W'(MAX_FIELD_WIDTH);

  itf_state_t state, state_next;

  // Captured item
  logic [1:0]       mode_r;
  logic [1:0]       sm_r;
  logic [FW_W-1:0]  fw_r;
  logic             grp_r, lj_r, zp_r, alt_r, uc_r, nz_r;

  // Digit source: octal/hex value or decimal BCD; shifts one digit per non-comma split cycle
  logic [BCD_W-1:0] src;
  logic [FW_W-1:0]  digit_count;
  logic [FW_W-1:0]  pad_remaining;
  logic [1:0]       mod3;
  logic             comma_due;

  logic             accept;
  logic             dab_start, dab_done;
  logic [BCD_W-1:0] dab_bcd;

  itf_stack_ctrl_t  stk;
  logic [7:0]       stack_top;

  logic             out_free;
  logic             emit;
  logic [7:0]       emit_char;
  logic             emit_last;

  logic             is_dec, is_oct;
  logic             want_prefix, want_sign, want_rpad;
  logic [FW_W-1:0]  pad_calc;
  logic [3:0]       split_digit;
  logic [BCD_W-1:0] src_shift;
  logic             src_last;
  logic [7:0]       sign_char;

  itf_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .value (s_tdata[VALUE_W-1:0]),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  itf_digit_stack u_stack (
    .clk      (clk),
    .ctrl     (stk),
    .top_char (stack_top)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign is_dec      = (mode_r == MODE_DEC);
  assign is_oct      = (mode_r == MODE_OCT);
  assign want_prefix = alt_r && nz_r && !is_dec;
  assign want_sign   = is_dec && (sm_r != SIGN_NONE);
  assign want_rpad   = lj_r && (pad_remaining != '0);
  assign pad_calc    = (fw_r > digit_count) ? fw_r - digit_count : '0;

  assign split_digit = is_oct ? {1'b0, src[2:0]} : src[3:0];
  assign src_shift   = is_oct ? (src >> 3) : (src >> 4);
  assign src_last    = (src_shift == '0);

  always_comb begin
    unique case (sm_r)
      SIGN_PLUS:  sign_char = CH_PLUS;
      SIGN_SPACE: sign_char = CH_SPACE;
      default:    sign_char = CH_MINUS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: split digits onto the stack, then walk prefix, sign, padding and digits
  always_comb begin
    state_next = state;
    dab_start  = 1'b0;
    stk        = '0;
    emit       = 1'b0;
    emit_char  = CH_SPACE;
    emit_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata[65:64] == MODE_DEC) begin
            dab_start  = 1'b1;
            state_next = S_DABBLE;
          end else begin
            state_next = S_SPLIT;
          end
        end
      end
      S_DABBLE: begin
        if (dab_done) begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        stk.push = 1'b1;
        if (comma_due) begin
          stk.data = CH_COMMA;
        end else begin
          stk.data = digit_char(split_digit, uc_r);
          if (src_last) begin
            state_next = S_PADCALC;
          end
        end
      end
      S_PADCALC: begin
        if (want_prefix) begin
          state_next = S_PREFIX_ZERO;
        end else if (want_sign) begin
          state_next = S_SIGN;
        end else if (!lj_r && pad_calc != '0) begin
          state_next = S_LPAD;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_PREFIX_ZERO: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_ZERO;
          if (!is_oct) begin
            state_next = S_PREFIX_X;
          end else if (!lj_r && pad_remaining != '0) begin
            state_next = S_LPAD;
          end else begin
            state_next = S_DIGIT;
          end
        end
      end
      S_PREFIX_X, S_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = (state == S_SIGN) ? sign_char : CH_X;
          if (!lj_r && pad_remaining != '0) begin
            state_next = S_LPAD;
          end else begin
            state_next = S_DIGIT;
          end
        end
      end
      S_LPAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = zp_r ? CH_ZERO : CH_SPACE;
          if (pad_remaining == FW_W'(1)) begin
            state_next = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = stack_top;
          stk.pop   = 1'b1;
          if (digit_count == FW_W'(1)) begin
            if (want_rpad) begin
              state_next = S_RPAD;
            end else begin
              emit_last  = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end
      S_RPAD: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = CH_SPACE;
          if (pad_remaining == FW_W'(1)) begin
            emit_last  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Item capture and digit source
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= s_tdata[65:64];
      fw_r   <= (s_tdata[71:66] > MAX_FW) ? MAX_FW : s_tdata[71:66];
      sm_r   <= s_tdata[73:72];
      grp_r  <= s_tdata[74];
      lj_r   <= s_tdata[75];
      zp_r   <= s_tdata[76];
      alt_r  <= s_tdata[77];
      uc_r   <= s_tdata[78];
      nz_r   <= (s_tdata[VALUE_W-1:0] != '0);
      src    <= {{(BCD_W-VALUE_W){1'b0}}, s_tdata[VALUE_W-1:0]};
    end else if (state == S_DABBLE && dab_done) begin
      src <= dab_bcd;
    end else if (state == S_SPLIT && !comma_due) begin
      src <= src_shift;
    end
  end

  // Counters: digits and commas on the stack, padding still to send, grouping phase
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      pad_remaining <= '0;
      mod3          <= '0;
      comma_due     <= 1'b0;
    end else begin
      if (accept) begin
        digit_count <= '0;
        mod3        <= '0;
        comma_due   <= 1'b0;
      end else if (state == S_SPLIT) begin
        digit_count <= digit_count + 1'b1;
        if (comma_due) begin
          comma_due <= 1'b0;
        end else begin
          mod3 <= (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
          if (mod3 == 2'd2 && grp_r) begin
            comma_due <= 1'b1;
          end
        end
      end else if (state == S_DIGIT && emit) begin
        digit_count <= digit_count - 1'b1;
      end

      if (state == S_PADCALC) begin
        pad_remaining <= pad_calc;
      end else if ((state == S_LPAD || state == S_RPAD) && emit) begin
        pad_remaining <= pad_remaining - 1'b1;
      end
    end
  end

  // Output register: load a character when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_last;
    end
  end

  // The stack never holds more than its depth
  assert property (@(posedge clk) disable iff (rst) digit_count <= FW_W'(STACK_DEPTH))
    else $error("digit stack overflow");

  // Digits are popped only while some remain
  assert property (@(posedge clk) disable iff (rst) (state == S_DIGIT) |-> (digit_count != '0))
    else $error("pop from empty digit stack");

  // Padding never exceeds the saturated field width
  assert property (@(posedge clk) disable iff (rst) pad_remaining <= MAX_FW)
    else $error("padding beyond field width");

  // The converter finishes only while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst) dab_done |-> (state == S_DABBLE))
    else $error("stray conversion done");

  // The final character returns the sequencer to idle
  assert property (@(posedge clk) disable iff (rst) (emit && emit_last) |=> (state == S_IDLE))
    else $error("last character without return to idle");

  // Padding states are entered only with padding left
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LPAD || state == S_RPAD) |-> (pad_remaining != '0))
    else $error("padding state with no padding left");

endmodule

FILE: rtl/itf_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module itf_dabble (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [itf_pkg::VALUE_W-1:0]  value,
  output logic                         done,
  output logic [itf_pkg::BCD_W-1:0]    bcd
);
  import itf_pkg::*;

  localparam int CNT_W = $clog2(DABBLE_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DABBLE_STEPS - 1);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   acc;
  logic [BCD_W-1:0]   acc_adj;
  logic [CNT_W-1:0]   count;
  logic               busy;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      acc_adj[4*i +: 4] = (acc[4*i +: 4] >= 4'd5) ? acc[4*i +: 4] + 4'd3 : acc[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == LAST_STEP);
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      acc <= '0;
    end else if (busy) begin
      acc <= {acc_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign bcd = acc;

endmodule

FILE: rtl/itf_digit_stack.sv
// Last-in first-out shift stack that turns least-first digits into most-first text.
module itf_digit_stack (
  input  logic                    clk,
  input  itf_pkg::itf_stack_ctrl_t ctrl,
  output logic [7:0]              top_char
);
  import itf_pkg::*;

  logic [7:0] entry [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      for (int i = STACK_DEPTH - 1; i > 0; i--) begin
        entry[i] <= entry[i-1];
      end
      entry[0] <= ctrl.data;
    end else if (ctrl.pop) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  assign top_char = entry[0];

endmodule

FILE: dv/tb_integer_to_text_formatter.sv
// Self-checking testbench for the integer-to-text formatter stream block.
`timescale 1ns / 100ps

module tb_integer_to_text_formatter;
  import itf_pkg::*;

  // Radix select three has no name in the package; the block treats it as hex
  localparam logic [1:0] MODE_HEX_ALIAS = 2'd3;
  localparam int RANDOM_NUMBERS = 385;
  localparam int SETTLE_CYCLES  = 200;
  localparam int MAX_REPORTS    = 10;

  // One number to format, laid out exactly as the low 79 bits of s_tdata
  typedef struct packed {
    logic        upper_case;
    logic        alt_form;
    logic        zero_pad;
    logic        left_justify;
    logic        group_digits;
    logic [1:0]  sign_mode;
    logic [5:0]  field_width;
    logic [1:0]  mode;
    logic [63:0] value;
  } fmt_req_t;

  // One directed row: the number and, where obvious, its text typed in by hand
  typedef struct {
    fmt_req_t req;
    string    text;
  } fmt_row_t;

  // One output character as it should appear on the master side
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // value[63:0], mode[65:64], field_width[71:66], sign_mode[73:72], group_digits[74],
  // left_justify[75], zero_pad[76], alt_form[77], upper_case[78], zero fill[79]
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // character[7:0]
  logic [7:0]  m_tdata;
  logic        m_tlast;

  text_beat_t  expected_text[$];
  fmt_row_t    directed_rows[$];
  int          fail_count;
  int          stall_pct;

  integer_to_text_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic fmt_req_t make_req(input logic [63:0] v, input logic [1:0] m,
                                        input logic [5:0] fw, input logic [1:0] sg,
                                        input logic grp, input logic lj, input logic zp,
                                        input logic alt, input logic uc);
    fmt_req_t r;
    r.value        = v;
    r.mode         = m;
    r.field_width  = fw;
    r.sign_mode    = sg;
    r.group_digits = grp;
    r.left_justify = lj;
    r.zero_pad     = zp;
    r.alt_form     = alt;
    r.upper_case   = uc;
    return r;
  endfunction

  // Build the whole text of one number: prefix, sign, left padding, grouped digits, right padding
  function automatic string format_number(input fmt_req_t r);
    logic [7:0]  digits [STACK_DEPTH];
    logic [63:0] rest;
    logic [63:0] radix;
    logic [3:0]  d;
    int          ndig;
    int          cnt;
    int          pad;
    int          width;
    string       s;
    radix = (r.mode == MODE_OCT) ? 64'd8 : (r.mode == MODE_DEC) ? 64'd10 : 64'd16;
    width = (int'(r.field_width) > DEF_MAX_FIELD_W) ? DEF_MAX_FIELD_W : int'(r.field_width);
    rest  = r.value;
    ndig  = 0;
    cnt   = 0;
    s     = "";
    // Collect digits least significant first; a comma only between full groups
    do begin
      if (r.group_digits && ndig != 0 && ndig % 3 == 0) begin
        digits[cnt % STACK_DEPTH] = CH_COMMA;
        cnt++;
      end
      d = 4'(rest % radix);
      if (d < 4'd10) begin
        digits[cnt % STACK_DEPTH] = CH_ZERO + 8'(d);
      end else begin
        digits[cnt % STACK_DEPTH] = (r.upper_case ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
      end
      cnt++;
      ndig++;
      rest = rest / radix;
    end while (rest != 0);
    pad = (width > cnt) ? width - cnt : 0;
    // A zero value never gets the alternative-form prefix
    if (r.alt_form && r.value != 0) begin
      if (radix == 64'd8) begin
        s = "0";
      end else if (radix == 64'd16) begin
        s = "0x";
      end
    end
    // Sign only for decimal
    if (radix == 64'd10) begin
      case (r.sign_mode)
        SIGN_PLUS:  s = {s, "+"};
        SIGN_SPACE: s = {s, " "};
        SIGN_MINUS: s = {s, "-"};
        default: ;
      endcase
    end
    // Left padding carries no commas, even with grouping on
    if (!r.left_justify) begin
      repeat (pad) begin
        if (r.zero_pad) begin
          s = {s, "0"};
        end else begin
          s = {s, " "};
        end
      end
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      s = $sformatf("%s%c", s, digits[k % STACK_DEPTH]);
    end
    if (r.left_justify) begin
      repeat (pad) s = {s, " "};
    end
    return s;
  endfunction

  // Queue the characters of one number, tlast on the final one
  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      expected_text.push_back('{s[i], i == s.len() - 1});
    end
  endfunction

  // Offer one number on the slave side and hold it until the block takes the beat
  task automatic send_number(input fmt_req_t r, input string typed);
    @(negedge clk);
    // Idle the sender at random before raising tvalid
    while ($urandom_range(0, 99) < stall_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, r};
    do @(posedge clk); while (!s_tready);
    if (typed.len() != 0) begin
      queue_text(typed);
    end else begin
      queue_text(format_number(r));
    end
  endtask

  // Drop tvalid and hold off until every queued character has come out
  task automatic drain_text();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_text.size() == 0);
  endtask

  // Sink side: stall tready at random, changes on the falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare every accepted output beat with the oldest queued character
  always @(posedge clk) begin : check_text
    text_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_text.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected beat at %0t: char %h last %b", $realtime, m_tdata, m_tlast);
        end
      end else begin
        want = expected_text.pop_front();
        if (m_tdata !== want.ch || m_tlast !== want.last) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected char %h last %b, got char %h last %b",
                     $realtime, want.ch, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [63:0] v;
    logic [5:0]  fw;
    fail_count = 0;
    stall_pct  = 21;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;

    // Directed rows: extremes, every radix and flag, and the odd corners
    directed_rows.push_back('{make_req(64'd0, MODE_DEC, 6'd0, SIGN_NONE, 0, 0, 0, 0, 0), "0"});
    directed_rows.push_back('{make_req('1, MODE_DEC, 6'd0, SIGN_NONE, 0, 0, 0, 0, 0),
                              "18446744073709551615"});
    directed_rows.push_back('{make_req('1, MODE_HEX, 6'd0, SIGN_NONE, 0, 0, 0, 1, 0),
                              "0xffffffffffffffff"});
    directed_rows.push_back('{make_req('1, MODE_HEX, 6'd0, SIGN_NONE, 0, 0, 0, 1, 1),
                              "0xFFFFFFFFFFFFFFFF"});
    directed_rows.push_back('{make_req('1, MODE_OCT, 6'd0, SIGN_NONE, 0, 0, 0, 1, 0),
                              "01777777777777777777777"});
    // Longest digit string: octal with grouping
    directed_rows.push_back('{make_req('1, MODE_OCT, 6'd0, SIGN_NONE, 1, 0, 0, 0, 0), ""});
    // Zero with alternative form gets no prefix
    directed_rows.push_back('{make_req(64'd0, MODE_HEX, 6'd0, SIGN_NONE, 0, 0, 0, 1, 0), "0"});
    directed_rows.push_back('{make_req(64'd0, MODE_OCT, 6'd0, SIGN_NONE, 0, 0, 0, 1, 0), "0"});
    directed_rows.push_back('{make_req(64'd1234567, MODE_DEC, 6'd0, SIGN_NONE, 1, 0, 0, 0, 0),
                              "1,234,567"});
    // Digit count a multiple of three: no leading comma
    directed_rows.push_back('{make_req(64'd123456, MODE_DEC, 6'd0, SIGN_NONE, 1, 0, 0, 0, 0),
                              "123,456"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd0, SIGN_PLUS, 0, 0, 0, 0, 0), "+42"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd0, SIGN_SPACE, 0, 0, 0, 0, 0), " 42"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd0, SIGN_MINUS, 0, 0, 0, 0, 0), "-42"});
    // Sign is ignored outside decimal
    directed_rows.push_back('{make_req(64'd8, MODE_OCT, 6'd0, SIGN_PLUS, 0, 0, 0, 1, 0), "010"});
    // Radix select three acts as hex
    directed_rows.push_back('{make_req(64'd255, MODE_HEX_ALIAS, 6'd0, SIGN_NONE, 0, 0, 0, 0, 0),
                              "ff"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd5, SIGN_NONE, 0, 0, 0, 0, 0), "   42"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd5, SIGN_NONE, 0, 0, 1, 0, 0), "00042"});
    directed_rows.push_back('{make_req(64'd42, MODE_DEC, 6'd5, SIGN_NONE, 0, 1, 1, 0, 0), "42   "});
    // Zero padding with grouping: pad zeros carry no commas
    directed_rows.push_back('{make_req(64'd1234, MODE_DEC, 6'd8, SIGN_NONE, 1, 0, 1, 0, 0),
                              "0001,234"});
    directed_rows.push_back('{make_req(64'hab, MODE_HEX, 6'd4, SIGN_NONE, 0, 0, 1, 1, 1), "0x00AB"});
    directed_rows.push_back('{make_req(64'd5, MODE_DEC, 6'd0, SIGN_NONE, 0, 0, 0, 1, 0), "5"});
    directed_rows.push_back('{make_req(64'd1000, MODE_DEC, 6'd6, SIGN_SPACE, 1, 0, 0, 0, 0),
                              "  1,000"});
    // Width beyond the limit saturates
    directed_rows.push_back('{make_req(64'd7, MODE_DEC, 6'd63, SIGN_MINUS, 0, 0, 0, 0, 0), ""});
    directed_rows.push_back('{make_req('1, MODE_DEC, 6'd48, SIGN_PLUS, 1, 1, 0, 0, 0), ""});
    directed_rows.push_back('{make_req(64'hdead_beef_0123_4567, MODE_HEX, 6'd49, SIGN_NONE,
                                       1, 0, 1, 0, 0), ""});

    // Hold reset, then release it on a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].req, directed_rows[i].text);
    end
    drain_text();

    // Random numbers; a middle stretch runs with no stalls on either side
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      stall_pct = (i >= 150 && i < 250) ? 0 : 21;
      case ($urandom_range(0, 3))
        0:       v = 64'($urandom_range(0, 9999));
        1:       v = {$urandom, $urandom};
        2:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
      endcase
      // Mostly short fields; now and then the full 6-bit range
      fw = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 20));
      send_number(make_req(v, 2'($urandom_range(0, 3)), fw, 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))), "");
      // Hold the sender off now and then until the sink has caught up
      if (i % 100 == 99) begin
        drain_text();
      end
    end

    drain_text();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_text.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
